/* rtl/rsbs_pkg.sv */
// ----------------------------------------------------------------------------
// rsbs_pkg: shared types and constants
// Word formats for the record sorter and the cell chain it uses.
// ----------------------------------------------------------------------------
package rsbs_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned TAG_W       = 8;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] out_score;
    logic [TAG_W-1:0]   out_tag;
    logic               final_res;
  } out_word_t;

  typedef struct packed {
    logic               vld;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctrl_t;

endpackage

/* rtl/record_sort_by_score_descending_core.sv */
// ----------------------------------------------------------------------------
// record_sort_by_score_descending_core: descending record sorter
// Channel | Dir | Handshake              | Payload
// in      | in  | in_valid_i/in_ready_o  | in_data_i  (score, tag, last)
// out     | out | out_valid_o/out_ready_i| out_data_o (out_score, out_tag, final_res)
// Loading takes one word per cycle; each word is placed in order in a chain
// of MaxEntries cells in the cycle it is accepted.
// After the last word, one result per unstalled cycle leaves the chain head;
// input is held off until the final result is in the output register.
// Reset empties the chain at once. Output stalls hold the chain.
// Words beyond MaxEntries are dropped; equal scores leave newest first.
// ----------------------------------------------------------------------------
module record_sort_by_score_descending_core #(
  parameter int unsigned MaxEntries = rsbs_pkg::MAX_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rsbs_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsbs_pkg::out_word_t out_data_o
);

  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  logic                out_valid_q;
  rsbs_pkg::out_word_t out_data_q;

  rsbs_pkg::entry_t     entry [MaxEntries];
  logic                 ge    [MaxEntries];
  rsbs_pkg::entry_t     new_entry;
  rsbs_pkg::cell_ctrl_t ctrl;
  logic                 accept;
  logic                 out_free;

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign ctrl.ins = accept && (count_q != CntW'(MaxEntries));
  assign ctrl.pop = (state_q == ST_EMIT) && out_free && (count_q != '0);

  assign new_entry.vld   = 1'b1;
  assign new_entry.score = in_data_i.score;
  assign new_entry.tag   = in_data_i.tag;

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    rsbs_pkg::entry_t prev_e;
    rsbs_pkg::entry_t next_e;
    logic             prev_ge;

    if (i == 0) begin : g_head
      assign prev_e  = '0;
      assign prev_ge = 1'b0;
    end else begin : g_body
      assign prev_e  = entry[i-1];
      assign prev_ge = ge[i-1];
    end

    if (i == MaxEntries - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = entry[i+1];
    end

    rsbs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (new_entry),
      .prev_i    (prev_e),
      .prev_ge_i (prev_ge),
      .next_i    (next_e),
      .entry_o   (entry[i]),
      .ge_o      (ge[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (ctrl.pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (ctrl.ins) begin
            count_q <= count_q + CntW'(1);
          end
          if (accept && in_data_i.last) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (ctrl.pop) begin
            out_data_q.out_score <= entry[0].score;
            out_data_q.out_tag   <= entry[0].tag;
            out_data_q.final_res <= (count_q == CntW'(1));
            count_q              <= count_q - CntW'(1);
            if (count_q == CntW'(1)) begin
              state_q <= ST_LOAD;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/rsbs_cell.sv */
// ----------------------------------------------------------------------------
// rsbs_cell: one slot of the sorting chain
// Holds one record. On insert it keeps, takes the new record, or takes its
// upper neighbor; on pop it takes its lower neighbor.
// ----------------------------------------------------------------------------
module rsbs_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsbs_pkg::cell_ctrl_t ctrl_i,
  input  rsbs_pkg::entry_t    new_i,
  input  rsbs_pkg::entry_t    prev_i,
  input  logic                prev_ge_i,
  input  rsbs_pkg::entry_t    next_i,
  output rsbs_pkg::entry_t    entry_o,
  output logic                ge_o
);

  rsbs_pkg::entry_t entry_q, entry_d;

  assign ge_o = !entry_q.vld || (new_i.score >= entry_q.score);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = next_i;
    end else if (ctrl_i.ins && ge_o) begin
      entry_d = prev_ge_i ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
